// ===== rtl/lkvc_pkg.sv =====
// lkvc_pkg: shared types and constants of the lru key/value cache
// used by the request interface, the entry store and the top level
package lkvc_pkg;

   // width of the capacity register
   localparam int CAP_BITS = 5;

   // operation codes of an input item
   typedef enum logic {
      KIND_LOOKUP = 1'b0,
      KIND_INSERT = 1'b1
   } kind_type;

   // outcome flags of one item, store to top level
   typedef struct packed {
      logic hit;
      logic evicted;
   } status_type;

endpackage

// ===== rtl/lkvc_req_if.sv =====
// lkvc_req_if: request channel of the lru key/value cache, valid/ready
// depends on lkvc_pkg for the operation code type
interface lkvc_req_if import lkvc_pkg::*; #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   kind_type              kind;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

// ===== rtl/lkvc_rsp_if.sv =====
// lkvc_rsp_if: response channel of the lru key/value cache, valid/ready
// no package dependency
interface lkvc_rsp_if #(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic                  hit;
   logic [VALUE_BITS-1:0] read_value;
   logic                  evicted;
   logic [KEY_BITS-1:0]   evicted_key;
   logic [VALUE_BITS-1:0] evicted_value;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, output evicted_value, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, input evicted_value, output ready);
endinterface

// ===== rtl/lkvc_store.sv =====
// lkvc_store: entry registers, parallel key match, lru ranks and replacement
// depends on lkvc_pkg; one item is applied per cycle when fire is high
module lkvc_store import lkvc_pkg::*; #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  kind_type              kind,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [VALUE_BITS-1:0] value,
   input  logic [CAP_BITS-1:0]   capacity,
   output status_type            status,
   output logic [VALUE_BITS-1:0] read_value,
   output logic [KEY_BITS-1:0]   evicted_key,
   output logic [VALUE_BITS-1:0] evicted_value
);

   localparam int RANK_BITS = $clog2(ENTRIES);
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;
   localparam logic [CMP_BITS-1:0] ENTRIES_C = CMP_BITS'(ENTRIES);

   logic [KEY_BITS-1:0]   keys_ff   [ENTRIES];
   logic [VALUE_BITS-1:0] values_ff [ENTRIES];
   logic [RANK_BITS-1:0]  rank_ff   [ENTRIES];
   logic [RANK_BITS-1:0]  rank_in   [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;

   logic [ENTRIES-1:0]    hit_oh, victim_oh, free_vec, new_oh;
   logic                  any_hit, do_evict, do_insert;
   logic [RANK_BITS-1:0]  hit_rank, lru_rank;
   logic [VALUE_BITS-1:0] hit_value, victim_value;
   logic [KEY_BITS-1:0]   victim_key;
   logic [CMP_BITS-1:0]   cap_ext, cap_use, occ_ext;

   // capacity in use, zero or oversize means the whole store
   assign cap_ext = CMP_BITS'(capacity);
   assign occ_ext = CMP_BITS'(occ_ff);
   assign cap_use = (cap_ext == '0 || cap_ext > ENTRIES_C) ? ENTRIES_C : cap_ext;

   // least recent valid entry carries rank occupancy - 1
   assign lru_rank = RANK_BITS'(occ_ff - OCC_BITS'(1));

   // parallel key match and victim match
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_oh[i]    = valid_ff[i] && (keys_ff[i] == key);
         victim_oh[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
      end
   end

   // one-hot selection of hit and victim fields
   always_comb begin
      hit_rank     = '0;
      hit_value    = '0;
      victim_key   = '0;
      victim_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_rank     = hit_rank     | (rank_ff[i]   & {RANK_BITS{hit_oh[i]}});
         hit_value    = hit_value    | (values_ff[i] & {VALUE_BITS{hit_oh[i]}});
         victim_key   = victim_key   | (keys_ff[i]   & {KEY_BITS{victim_oh[i]}});
         victim_value = victim_value | (values_ff[i] & {VALUE_BITS{victim_oh[i]}});
      end
   end

   assign any_hit   = |hit_oh;
   assign do_insert = (kind == KIND_INSERT) && !any_hit;
   assign do_evict  = do_insert && (occ_ext >= cap_use) && (occ_ff != '0);

   // lowest free slot, counting the slot freed by eviction
   assign free_vec = ~valid_ff | (victim_oh & {ENTRIES{do_evict}});
   assign new_oh   = free_vec & (~free_vec + ENTRIES'(1));

   // result fields, zero where not meaningful
   assign status.hit     = any_hit;
   assign status.evicted = do_evict;
   assign read_value     = any_hit ? hit_value : '0;
   assign evicted_key    = do_evict ? victim_key : '0;
   assign evicted_value  = do_evict ? victim_value : '0;

   // next valid bits, ranks and occupancy
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      priority if (any_hit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < hit_rank) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end
      end else if (do_insert) begin
         valid_in = (valid_ff & ~(victim_oh & {ENTRIES{do_evict}})) | new_oh;
         occ_in   = do_evict ? occ_ff : occ_ff + OCC_BITS'(1);
         for (int i = 0; i < ENTRIES; i++) begin
            if (new_oh[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && !(do_evict && victim_oh[i])) begin
               rank_in[i] = rank_ff[i] + RANK_BITS'(1);
            end
         end
      end else begin
         occ_in = occ_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (fire) begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // key and value payload, written on insert
   always_ff @(posedge clock) begin
      if (fire && kind == KIND_INSERT) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (any_hit && hit_oh[i]) begin
               values_ff[i] <= value;
            end else if (!any_hit && new_oh[i]) begin
               keys_ff[i]   <= key;
               values_ff[i] <= value;
            end
         end
      end
   end

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// lru_key_value_cache_top: fully associative key/value cache with lru replacement
// depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and lkvc_store
//
// Usage:
//   req_ch carries one item per valid/ready handshake: kind (lookup or insert),
//   key and value. rsp_ch returns exactly one item per request, in order:
//   hit, read_value, evicted, evicted_key, evicted_value.
//   csr_wr_en/csr_wr_data write the capacity register (entries in use before
//   eviction starts); zero or a value above ENTRIES means all ENTRIES.
//   Write it only while no item is in flight.
// Timing:
//   an accepted item is held in the input register, then applied to the store
//   as it moves to the response register, which then presents its response.
//   One item per cycle is sustained while rsp_ch.ready is high; the key match
//   against all entries, rank update and replacement choice are combinational.
// Reset:
//   synchronous reset empties the cache (all entries invalid, occupancy zero),
//   drops any item in flight and sets the capacity to ENTRIES.
// Backpressure:
//   when rsp_ch.ready is low the response register holds; one more item may
//   wait in the input register, after which req_ch.ready falls.
module lru_key_value_cache_top import lkvc_pkg::*; #(
   parameter int ENTRIES    = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   lkvc_req_if.sink            req_ch,
   lkvc_rsp_if.source          rsp_ch,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
);

   logic                  s1_vld_ff, s1_vld_in;
   kind_type              s1_kind_ff;
   logic [KEY_BITS-1:0]   s1_key_ff;
   logic [VALUE_BITS-1:0] s1_val_ff;

   logic                  rsp_vld_ff, rsp_vld_in;
   status_type            rsp_status_ff;
   logic [VALUE_BITS-1:0] rsp_rval_ff;
   logic [KEY_BITS-1:0]   rsp_ekey_ff;
   logic [VALUE_BITS-1:0] rsp_eval_ff;

   logic [CAP_BITS-1:0]   capacity_ff;

   logic                  req_acc, advance;
   status_type            st_status;
   logic [VALUE_BITS-1:0] st_rval, st_eval;
   logic [KEY_BITS-1:0]   st_ekey;

   // handshake control
   assign advance      = s1_vld_ff && (!rsp_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_vld_ff || advance;
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign s1_vld_in  = req_acc ? 1'b1 : (advance ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         capacity_ff <= CAP_BITS'(ENTRIES);
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_kind_ff <= req_ch.kind;
         s1_key_ff  <= req_ch.key;
         s1_val_ff  <= req_ch.value;
      end
   end

   // entry store, updated as the item moves to the response register
   lkvc_store #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .kind          (s1_kind_ff),
      .key           (s1_key_ff),
      .value         (s1_val_ff),
      .capacity      (capacity_ff),
      .status        (st_status),
      .read_value    (st_rval),
      .evicted_key   (st_ekey),
      .evicted_value (st_eval)
   );

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= st_status;
         rsp_rval_ff   <= st_rval;
         rsp_ekey_ff   <= st_ekey;
         rsp_eval_ff   <= st_eval;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.hit           = rsp_status_ff.hit;
   assign rsp_ch.read_value    = rsp_rval_ff;
   assign rsp_ch.evicted       = rsp_status_ff.evicted;
   assign rsp_ch.evicted_key   = rsp_ekey_ff;
   assign rsp_ch.evicted_value = rsp_eval_ff;

endmodule
